// ----- rtl/qscr_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// qscr_pkg
// Shared types and constants for the query score combine and rank block.
// ============================================================================
package qscr_pkg;

    // Score map geometry
    localparam int PAGES      = 1024;
    localparam int SCORE_BITS = 32;
    localparam int PAGE_BITS  = $clog2(PAGES);

    localparam logic [PAGE_BITS-1:0] LAST_PAGE = PAGE_BITS'(PAGES - 1);
    localparam logic [63:0]          SCORE_MAX = 64'({SCORE_BITS{1'b1}});
    localparam logic [63:0]          OUT_MAX   = 64'hFFFF_FFFF;

    typedef logic [SCORE_BITS-1:0] score_t;
    typedef logic [PAGE_BITS-1:0]  page_addr_t;

    // Command codes
    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_ENTRY     = 2'd1;
    localparam logic [1:0] OP_NOT_FOUND = 2'd2;
    localparam logic [1:0] OP_FETCH     = 2'd3;

    // Command beat
    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  page;
        logic [31:0] hit_count;
        logic        is_stopword;
        logic        last_entry;
    } cmd_beat_t;

    // Result beat
    typedef struct packed {
        logic        found;
        logic [9:0]  best_page;
        logic [31:0] best_score;
    } result_beat_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_ENTRY = 4'b0100,
        S_SCAN  = 4'b1000
    } state_t;

endpackage

// ----- rtl/query_score_combine_and_rank_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// query_score_combine_and_rank_core
// Per-page score map for one search query: folds word hit streams into a
// score memory and returns the best remaining page on fetch.
// ============================================================================
//
//   channel   | handshake           | payload
//   ----------+---------------------+--------------------
//   command   | start / busy        | cmd    (cmd_beat_t)
//   result    | done (strobe)       | result (result_beat_t)
//
// Word entry: a read, then a modify-write of the score memory. Fetch: a
// linear scan over the score memory, one entry per cycle, then the result
// beat. Clear and reset: busy for the clearing pass over the score memory.
// Not-found, and a word entry or a fetch on a failed query, leave busy low.
// The result beat is valid while done, a one-cycle strobe, is high; the
// receiver cannot stall it.
//
module query_score_combine_and_rank_core
    import qscr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  cmd_beat_t    cmd,
    output logic         done,
    output result_beat_t result
);

    // Control state
    state_t       state_reg, state_next;
    page_addr_t   idx_reg, idx_next;
    logic         map_empty_reg, map_empty_next;
    logic         real_seen_reg, real_seen_next;
    logic         failed_reg, failed_next;
    logic         done_reg, done_next;

    // Payload state
    score_t       mem [PAGES];
    score_t       rd_data_reg;
    logic [31:0]  hits_reg;
    logic         stop_reg;
    logic         last_reg;
    logic         in_range_reg;
    page_addr_t   entry_addr_reg;
    score_t       best_reg, best_next;
    page_addr_t   best_idx_reg, best_idx_next;
    result_beat_t result_reg, result_next;

    // Combinational
    logic         accept;
    logic         load_cmd;
    logic         mem_we;
    page_addr_t   mem_waddr;
    score_t       mem_wdata;
    page_addr_t   rd_addr;
    page_addr_t   cmd_addr;
    logic         cmd_in_range;
    score_t       addend;
    score_t       sum_sat;
    score_t       new_score;

    // Clamp a 32-bit count to the score range
    function automatic score_t clamp_count(input logic [31:0] h);
        logic [63:0] w;
        w = 64'(h);
        if (w > SCORE_MAX) begin
            return '1;
        end
        return SCORE_BITS'(w);
    endfunction

    // Saturating add on scores
    function automatic score_t add_sat(input score_t a, input score_t b);
        logic [SCORE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[SCORE_BITS]) begin
            return '1;
        end
        return s[SCORE_BITS-1:0];
    endfunction

    // Saturate a score to the 32-bit result field
    function automatic logic [31:0] out_score(input score_t s);
        logic [63:0] w;
        w = 64'(s);
        if (w > OUT_MAX) begin
            return '1;
        end
        return w[31:0];
    endfunction

    assign accept       = start && !busy;
    assign busy         = (state_reg != S_IDLE);
    assign cmd_addr     = PAGE_BITS'(cmd.page);
    assign cmd_in_range = (32'(cmd.page) < 32'(PAGES));

    // Combine rule for one word entry
    always_comb
    begin
        addend  = stop_reg ? clamp_count(hits_reg >> 1) : clamp_count(hits_reg);
        sum_sat = add_sat(rd_data_reg, addend);
        if (map_empty_reg) begin
            new_score = addend;
        end else if (stop_reg) begin
            new_score = sum_sat;
        end else if (!real_seen_reg) begin
            new_score = (hits_reg != '0) ? sum_sat : '0;
        end else begin
            new_score = (rd_data_reg != '0 && hits_reg != '0) ? sum_sat : '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        map_empty_next = map_empty_reg;
        real_seen_next = real_seen_reg;
        failed_next    = failed_reg;
        done_next      = 1'b0;
        load_cmd       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        rd_addr        = PAGE_BITS'(idx_reg + 1'b1);
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        result_next    = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = (cmd.op == OP_FETCH) ? '0 : cmd_addr;
                if (accept) begin
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            state_next     = S_CLEAR;
                            idx_next       = '0;
                            map_empty_next = 1'b1;
                            real_seen_next = 1'b0;
                            failed_next    = 1'b0;
                        end
                        OP_ENTRY:
                        begin
                            if (!failed_reg) begin
                                state_next = S_ENTRY;
                                load_cmd   = 1'b1;
                            end
                        end
                        OP_NOT_FOUND:
                        begin
                            failed_next = 1'b1;
                        end
                        OP_FETCH:
                        begin
                            if (failed_reg) begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end else begin
                                state_next    = S_SCAN;
                                idx_next      = '0;
                                best_next     = '0;
                                best_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                // Zero one entry per cycle
                mem_we = 1'b1;
                if (idx_reg == LAST_PAGE) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next = PAGE_BITS'(idx_reg + 1'b1);
                end
            end
            S_ENTRY:
            begin
                // Write back the combined score and advance the word flags
                mem_we     = in_range_reg;
                mem_waddr  = entry_addr_reg;
                mem_wdata  = new_score;
                state_next = S_IDLE;
                if (last_reg) begin
                    map_empty_next = 1'b0;
                    if (!stop_reg) begin
                        real_seen_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // Keep the first strictly larger score
                if (rd_data_reg > best_reg) begin
                    best_next     = rd_data_reg;
                    best_idx_next = idx_reg;
                end
                if (idx_reg == LAST_PAGE) begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (best_next != '0) begin
                        mem_we                 = 1'b1;
                        mem_waddr              = best_idx_next;
                        result_next.found      = 1'b1;
                        result_next.best_page  = 10'(best_idx_next);
                        result_next.best_score = out_score(best_next);
                    end else begin
                        result_next = '0;
                    end
                end else begin
                    idx_next = PAGE_BITS'(idx_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            map_empty_reg <= 1'b1;
            real_seen_reg <= 1'b0;
            failed_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            map_empty_reg <= map_empty_next;
            real_seen_reg <= real_seen_next;
            failed_reg    <= failed_next;
            done_reg      <= done_next;
        end
    end

    // Score memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Hold the entry beat and scan results
    always_ff @(posedge clk)
    begin
        if (load_cmd) begin
            hits_reg       <= cmd.hit_count;
            stop_reg       <= cmd.is_stopword;
            last_reg       <= cmd.last_entry;
            in_range_reg   <= cmd_in_range;
            entry_addr_reg <= cmd_addr;
        end
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/qscr_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// qscr_checker
// Port-level checks for the query score combine and rank block.
// ============================================================================
module qscr_checker
    import qscr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input cmd_beat_t    cmd,
    input logic         done,
    input result_beat_t result
);

    // An empty answer carries zero page and score
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> result.best_page == '0 && result.best_score == '0)
        else $error("empty result beat carries nonzero payload");

    // A found page has a nonzero score
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> result.best_score != '0)
        else $error("found result with zero score");

    // A result beat follows an accepted fetch or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || ($past(start) && $past(cmd.op) == OP_FETCH))
        else $error("result beat without a fetch");

    // An accepted clear starts the clearing pass
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.op == OP_CLEAR |=> busy)
        else $error("clear did not start clearing pass");

endmodule

bind query_score_combine_and_rank_core qscr_checker u_qscr_checker (.*);
